### rtl/w2s_pkg.sv
package w2s_pkg;

   // Fixed widths that follow from the 32-bit item fields.
   localparam int FIELD_W = 32;
   localparam int PROD_W = 64;
   localparam int SUM_W = 66;
   localparam int QUO_W = 33;
   localparam int LANES = 3;
   localparam int ELEMENTS = 16;
   localparam int ELEM_IDX_W = 4;
   localparam int CSR_IDX_W = 3;

   // Item opcodes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_PROJECT = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH = 3'd4;

   // Lane order inside the divider: x, y, z.
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;

   // Per-item flags that ride along with the quotient lanes.
   typedef struct packed {
      logic [LANES-1:0] neg;
      logic             w_zero;
   } flags_type;

endpackage

### rtl/w2s_dot.sv
module w2s_dot #(
   parameter int FRAC_BITS = 16,
   parameter int CLIP_W = 50,
   parameter int REM_W = 84
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [w2s_pkg::ELEMENTS-1:0][w2s_pkg::FIELD_W-1:0] matrix,
   input  logic signed [w2s_pkg::FIELD_W-1:0] point_x,
   input  logic signed [w2s_pkg::FIELD_W-1:0] point_y,
   input  logic signed [w2s_pkg::FIELD_W-1:0] point_z,
   output logic out_valid,
   input  logic out_ready,
   output logic [w2s_pkg::LANES-1:0][REM_W-1:0] out_rem,
   output logic [CLIP_W-1:0] out_div,
   output w2s_pkg::flags_type out_flags
);

   localparam int SW = w2s_pkg::SUM_W;
   localparam int PW = w2s_pkg::PROD_W;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   logic [3:0][3:0][PW-1:0] prod_ff, prod_in;
   logic [3:0][1:0][SW-1:0] pair_ff, pair_in;
   logic [3:0][CLIP_W-1:0] clip_ff, clip_in;
   logic [w2s_pkg::LANES-1:0][REM_W-1:0] rem_ff, rem_in;
   logic [CLIP_W-1:0] div_ff, div_in;
   w2s_pkg::flags_type flags_ff, flags_in;

   // Each stage moves when it is empty or its successor moves.
   assign rdy4 = !v4_ff || out_ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage 1: the twelve point products and the scaled translation column.
   always_comb begin
      logic signed [w2s_pkg::FIELD_W-1:0] pt [3];
      logic signed [w2s_pkg::FIELD_W-1:0] m;
      logic signed [PW-1:0] p;
      pt[0] = point_x;
      pt[1] = point_y;
      pt[2] = point_z;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            m = matrix[r*4+c];
            p = m * pt[c];
            prod_in[r][c] = p;
         end
         m = matrix[r*4+3];
         prod_in[r][3] = PW'($signed(PW'(m)) <<< FRAC_BITS);
      end
   end

   // Stage 2: pairwise sums.
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int h = 0; h < 2; h++) begin
            pair_in[r][h] = SW'($signed(prod_ff[r][2*h])) + SW'($signed(prod_ff[r][2*h+1]));
         end
      end
   end

   // Stage 3: row total, floored back to the fixed-point scale.
   always_comb begin
      logic signed [SW-1:0] total;
      for (int r = 0; r < 4; r++) begin
         total = $signed(pair_ff[r][0]) + $signed(pair_ff[r][1]);
         clip_in[r] = CLIP_W'(total >>> FRAC_BITS);
      end
   end

   // Stage 4: magnitudes, signs and the scaled dividends.
   always_comb begin
      logic [CLIP_W-1:0] mag;
      logic w_neg;
      w_neg = clip_ff[3][CLIP_W-1];
      div_in = w_neg ? CLIP_W'(-clip_ff[3]) : clip_ff[3];
      for (int l = 0; l < w2s_pkg::LANES; l++) begin
         mag = clip_ff[l][CLIP_W-1] ? CLIP_W'(-clip_ff[l]) : clip_ff[l];
         rem_in[l] = REM_W'(mag) << FRAC_BITS;
      end
      flags_in.neg[w2s_pkg::LANE_X] = clip_ff[0][CLIP_W-1] ^ w_neg;
      flags_in.neg[w2s_pkg::LANE_Y] = clip_ff[1][CLIP_W-1] ^ w_neg;
      flags_in.neg[w2s_pkg::LANE_Z] = clip_ff[2][CLIP_W-1];
      flags_in.w_zero = (clip_ff[3] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) prod_ff <= prod_in;
      if (rdy2) pair_ff <= pair_in;
      if (rdy3) clip_ff <= clip_in;
      if (rdy4) begin
         rem_ff <= rem_in;
         div_ff <= div_in;
         flags_ff <= flags_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_rem = rem_ff;
   assign out_div = div_ff;
   assign out_flags = flags_ff;

endmodule

### rtl/w2s_div_cell.sv
module w2s_div_cell #(
   parameter int REM_W = 84,
   parameter int DIV_W = 50,
   parameter int SHIFT = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic up_valid,
   output logic up_ready,
   input  logic [w2s_pkg::LANES-1:0][REM_W-1:0] up_rem,
   input  logic [w2s_pkg::LANES-1:0][w2s_pkg::QUO_W-1:0] up_quo,
   input  logic [DIV_W-1:0] up_div,
   input  w2s_pkg::flags_type up_flags,
   output logic dn_valid,
   input  logic dn_ready,
   output logic [w2s_pkg::LANES-1:0][REM_W-1:0] dn_rem,
   output logic [w2s_pkg::LANES-1:0][w2s_pkg::QUO_W-1:0] dn_quo,
   output logic [DIV_W-1:0] dn_div,
   output w2s_pkg::flags_type dn_flags
);

   logic valid_ff;
   logic [w2s_pkg::LANES-1:0][REM_W-1:0] rem_ff, rem_in;
   logic [w2s_pkg::LANES-1:0][w2s_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] div_ff;
   w2s_pkg::flags_type flags_ff;
   logic [REM_W-1:0] trial;

   assign up_ready = !valid_ff || dn_ready;

   // One restoring step: this cell decides quotient bit SHIFT in every lane.
   always_comb begin
      trial = REM_W'(up_div) << SHIFT;
      for (int l = 0; l < w2s_pkg::LANES; l++) begin
         if (up_rem[l] >= trial) begin
            rem_in[l] = up_rem[l] - trial;
            quo_in[l] = up_quo[l] | (w2s_pkg::QUO_W'(1) << SHIFT);
         end else begin
            rem_in[l] = up_rem[l];
            quo_in[l] = up_quo[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         div_ff <= up_div;
         flags_ff <= up_flags;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem = rem_ff;
   assign dn_quo = quo_ff;
   assign dn_div = div_ff;
   assign dn_flags = flags_ff;

endmodule

### rtl/w2s_map.sv
module w2s_map #(
   parameter int FRAC_BITS = 16,
   parameter int VIEWPORT_BITS = 14
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [w2s_pkg::LANES-1:0][w2s_pkg::QUO_W-1:0] in_quo,
   input  w2s_pkg::flags_type in_flags,
   input  logic [VIEWPORT_BITS-1:0] vp_left,
   input  logic [VIEWPORT_BITS-1:0] vp_top,
   input  logic [VIEWPORT_BITS-1:0] vp_width,
   input  logic [VIEWPORT_BITS-1:0] vp_height,
   input  logic depth_sym,
   output logic out_valid,
   input  logic out_ready,
   output logic signed [w2s_pkg::FIELD_W-1:0] screen_x,
   output logic signed [w2s_pkg::FIELD_W-1:0] screen_y,
   output logic signed [w2s_pkg::FIELD_W-1:0] screen_depth,
   output logic status
);

   localparam int FW = w2s_pkg::FIELD_W;
   localparam int MW = FW + VIEWPORT_BITS + 2;
   localparam int AW = MW + 1;
   localparam logic signed [FW:0] ONE_FX = (FW + 1)'(1) << FRAC_BITS;
   localparam logic signed [AW-1:0] SAT_HI = AW'(2147483647);
   localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);
   localparam logic [FW-1:0] FX_MAX = 32'h7fff_ffff;
   localparam logic [FW-1:0] FX_MIN = 32'h8000_0000;

   logic va_ff, vb_ff, vc_ff;
   logic rdya, rdyb, rdyc;
   logic [w2s_pkg::LANES-1:0][FW-1:0] p_ff, p_in;
   logic zero_a_ff, zero_b_ff;
   logic signed [MW-1:0] mx_ff, mx_in, my_ff, my_in;
   logic signed [FW-1:0] dz_ff, dz_in;
   logic signed [FW-1:0] sx_in, sy_in;

   assign rdyc = !vc_ff || out_ready;
   assign rdyb = !vb_ff || rdyc;
   assign rdya = !va_ff || rdyb;
   assign in_ready = rdya;

   // Stage A: apply the sign to each quotient and saturate.
   always_comb begin
      logic [FW-1:0] q;
      for (int l = 0; l < w2s_pkg::LANES; l++) begin
         q = in_quo[l][FW-1:0];
         if (in_quo[l][FW]) begin
            p_in[l] = in_flags.neg[l] ? FX_MIN : FX_MAX;
         end else if (in_flags.neg[l]) begin
            p_in[l] = (q > FX_MIN) ? FX_MIN : FW'(-q);
         end else begin
            p_in[l] = q[FW-1] ? FX_MAX : q;
         end
      end
   end

   // Stage B: scale (p + 1) by the viewport size; rescale depth if asked.
   always_comb begin
      logic signed [FW:0] px1, py1, pz1;
      logic signed [VIEWPORT_BITS:0] w_s, h_s;
      px1 = $signed({p_ff[w2s_pkg::LANE_X][FW-1], p_ff[w2s_pkg::LANE_X]}) + ONE_FX;
      py1 = $signed({p_ff[w2s_pkg::LANE_Y][FW-1], p_ff[w2s_pkg::LANE_Y]}) + ONE_FX;
      pz1 = $signed({p_ff[w2s_pkg::LANE_Z][FW-1], p_ff[w2s_pkg::LANE_Z]}) + ONE_FX;
      w_s = $signed({1'b0, vp_width});
      h_s = $signed({1'b0, vp_height});
      mx_in = px1 * w_s;
      my_in = py1 * h_s;
      dz_in = depth_sym ? FW'(pz1 >>> 1) : $signed(p_ff[w2s_pkg::LANE_Z]);
   end

   // Stage C: halve, add the origin and saturate.
   always_comb begin
      logic signed [AW-1:0] ox, oy, tx, ty;
      ox = $signed(AW'({vp_left, FRAC_BITS'(0)}));
      oy = $signed(AW'({vp_top, FRAC_BITS'(0)}));
      tx = ox + AW'(mx_ff >>> 1);
      ty = oy + AW'(my_ff >>> 1);
      if (tx > SAT_HI) sx_in = $signed(FX_MAX);
      else if (tx < SAT_LO) sx_in = $signed(FX_MIN);
      else sx_in = FW'(tx);
      if (ty > SAT_HI) sy_in = $signed(FX_MAX);
      else if (ty < SAT_LO) sy_in = $signed(FX_MIN);
      else sy_in = FW'(ty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (rdya) va_ff <= in_valid;
         if (rdyb) vb_ff <= va_ff;
         if (rdyc) vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdya) begin
         p_ff <= p_in;
         zero_a_ff <= in_flags.w_zero;
      end
      if (rdyb) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
         dz_ff <= dz_in;
         zero_b_ff <= zero_a_ff;
      end
      if (rdyc) begin
         screen_x <= zero_b_ff ? '0 : sx_in;
         screen_y <= zero_b_ff ? '0 : sy_in;
         screen_depth <= zero_b_ff ? '0 : dz_ff;
         status <= zero_b_ff;
      end
   end

   assign out_valid = vc_ff;

endmodule

### rtl/world_to_screen_projection.sv
// Projects points through a loaded 4x4 matrix into viewport pixels, in signed
// fixed point with FRAC_BITS fraction bits. An item with opcode load writes
// one matrix element at once and gives no result; a project item gives one
// result, and one item can be taken every cycle while req_stall is low.
// The divider is a chain of 33 cells that each settle one quotient bit for
// x, y and z at once (the first cell detects overflow), behind the matrix
// product and sum stages and ahead of the sign, saturation and viewport
// mapping stages. Every stage moves whenever the one after it is empty or
// moving, so empty slots close up under rsp_stall and items keep being taken
// until the chain is full. Configuration is written through
// csr_valid/csr_index/csr_data and is always ready.
module world_to_screen_projection #(
   parameter int FRAC_BITS = 16,
   parameter int VIEWPORT_BITS = 14
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_opcode,
   input  logic [w2s_pkg::ELEM_IDX_W-1:0] req_element_index,
   input  logic signed [w2s_pkg::FIELD_W-1:0] req_element_value,
   input  logic signed [w2s_pkg::FIELD_W-1:0] req_point_x,
   input  logic signed [w2s_pkg::FIELD_W-1:0] req_point_y,
   input  logic signed [w2s_pkg::FIELD_W-1:0] req_point_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [w2s_pkg::FIELD_W-1:0] rsp_screen_x,
   output logic signed [w2s_pkg::FIELD_W-1:0] rsp_screen_y,
   output logic signed [w2s_pkg::FIELD_W-1:0] rsp_screen_depth,
   output logic rsp_status,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [w2s_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [VIEWPORT_BITS-1:0] csr_data
);

   localparam int CLIP_W = w2s_pkg::SUM_W - FRAC_BITS;
   localparam int REM_W = CLIP_W + 34;
   localparam int CELLS = w2s_pkg::QUO_W;
   localparam int LN = w2s_pkg::LANES;

   logic [w2s_pkg::ELEMENTS-1:0][w2s_pkg::FIELD_W-1:0] matrix_ff;
   logic [VIEWPORT_BITS-1:0] left_ff, top_ff, width_ff, height_ff;
   logic depth_sym_ff;
   logic dot_ready;
   logic load_accept;

   logic [CELLS:0] chain_valid, chain_ready;
   logic [LN-1:0][REM_W-1:0] chain_rem [CELLS+1];
   logic [LN-1:0][w2s_pkg::QUO_W-1:0] chain_quo [CELLS+1];
   logic [CLIP_W-1:0] chain_div [CELLS+1];
   w2s_pkg::flags_type chain_flags [CELLS+1];

   assign req_stall = !dot_ready;
   assign load_accept = req_valid && !req_stall && (req_opcode == w2s_pkg::OP_LOAD);
   assign csr_ready = 1'b1;

   // Matrix store, cleared by reset and written by load items.
   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= '0;
      end else if (load_accept) begin
         matrix_ff[req_element_index] <= req_element_value;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         top_ff <= '0;
         width_ff <= VIEWPORT_BITS'(1920);
         height_ff <= VIEWPORT_BITS'(1080);
         depth_sym_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            w2s_pkg::CSR_LEFT: left_ff <= csr_data;
            w2s_pkg::CSR_TOP: top_ff <= csr_data;
            w2s_pkg::CSR_WIDTH: width_ff <= csr_data;
            w2s_pkg::CSR_HEIGHT: height_ff <= csr_data;
            w2s_pkg::CSR_DEPTH: depth_sym_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Clip-space products and sums.
   w2s_dot #(
      .FRAC_BITS(FRAC_BITS),
      .CLIP_W(CLIP_W),
      .REM_W(REM_W)
   ) u_dot (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid && (req_opcode == w2s_pkg::OP_PROJECT)),
      .in_ready(dot_ready),
      .matrix(matrix_ff),
      .point_x(req_point_x),
      .point_y(req_point_y),
      .point_z(req_point_z),
      .out_valid(chain_valid[0]),
      .out_ready(chain_ready[0]),
      .out_rem(chain_rem[0]),
      .out_div(chain_div[0]),
      .out_flags(chain_flags[0])
   );

   assign chain_quo[0] = '0;

   // Divider chain, most significant quotient bit first.
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      w2s_div_cell #(
         .REM_W(REM_W),
         .DIV_W(CLIP_W),
         .SHIFT(CELLS - 1 - i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .up_valid(chain_valid[i]),
         .up_ready(chain_ready[i]),
         .up_rem(chain_rem[i]),
         .up_quo(chain_quo[i]),
         .up_div(chain_div[i]),
         .up_flags(chain_flags[i]),
         .dn_valid(chain_valid[i+1]),
         .dn_ready(chain_ready[i+1]),
         .dn_rem(chain_rem[i+1]),
         .dn_quo(chain_quo[i+1]),
         .dn_div(chain_div[i+1]),
         .dn_flags(chain_flags[i+1])
      );
   end

   // Sign, saturation and viewport mapping.
   w2s_map #(
      .FRAC_BITS(FRAC_BITS),
      .VIEWPORT_BITS(VIEWPORT_BITS)
   ) u_map (
      .clock(clock),
      .reset(reset),
      .in_valid(chain_valid[CELLS]),
      .in_ready(chain_ready[CELLS]),
      .in_quo(chain_quo[CELLS]),
      .in_flags(chain_flags[CELLS]),
      .vp_left(left_ff),
      .vp_top(top_ff),
      .vp_width(width_ff),
      .vp_height(height_ff),
      .depth_sym(depth_sym_ff),
      .out_valid(rsp_valid),
      .out_ready(!rsp_stall),
      .screen_x(rsp_screen_x),
      .screen_y(rsp_screen_y),
      .screen_depth(rsp_screen_depth),
      .status(rsp_status)
   );

   // A zero w gives zero coordinates.
   a_zero_w_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |->
         rsp_screen_x == '0 && rsp_screen_y == '0 && rsp_screen_depth == '0)
      else $error("failure status with nonzero coordinates");

   // A load item lands in the addressed element.
   a_load_writes : assert property (@(posedge clock) disable iff (reset)
      load_accept |=> matrix_ff[$past(req_element_index)] == $past(req_element_value))
      else $error("matrix element not written by load item");

   // Reset leaves the matrix cleared.
   a_reset_clears : assert property (@(posedge clock)
      reset |=> matrix_ff == '0)
      else $error("matrix store not cleared by reset");

   // A depth mode write takes effect.
   a_depth_write : assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_index == w2s_pkg::CSR_DEPTH |=>
         depth_sym_ff == $past(csr_data[0]))
      else $error("depth mode register not written");

endmodule
